[hw/rtl/spq_pkg.sv]
// Shared package for the sorted priority queue.
// Holds codes, state and command/status types used by the controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  // Port field widths fixed by the stream format.
  localparam int unsigned IN_PRIO_BITS   = 16;
  localparam int unsigned IN_VALUE_BITS  = 32;
  localparam int unsigned IN_TDATA_BITS  = 48;
  localparam int unsigned IN_TUSER_BITS  = 1;
  localparam int unsigned OUT_PRIO_BITS  = 16;
  localparam int unsigned OUT_VALUE_BITS = 32;
  localparam int unsigned OUT_COUNT_BITS = 5;
  localparam int unsigned OUT_TDATA_BITS = 88;
  localparam int unsigned OUT_TUSER_BITS = 2;

  // Operation codes carried in in_tuser.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DEQ_RD,
    ST_DEQ_CAP,
    ST_HEAD_RD,
    ST_FINISH
  } state_t;

  typedef enum logic {
    RD_HEAD,
    RD_SCAN
  } rd_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load_req;    // capture the accepted word
    rd_sel_t rd_sel;      // memory read address source
    logic    pos_load;    // start insertion scan at the tail
    logic    pos_dec;     // step insertion scan toward the head
    logic    shift_wr;    // move the entry just read one slot toward the tail
    logic    ins_wr;      // write the new pair and bump the count
    logic    deq_commit;  // take the head pair, advance head, drop the count
    logic    set_status;  // record a refusal code
    status_t status;
    logic    out_load;    // publish the result word
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic pos_zero;
    logic greater;   // entry read has a strictly larger priority than the new one
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/spq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/spq_ctrl.sv]
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg for states and the command/status structs.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t  cmd
);

  spq_pkg::state_t state_r;
  spq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = spq_pkg::RD_HEAD;
    cmd.status     = spq_pkg::STAT_DONE;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = spq_pkg::ST_DISPATCH;
        end
      end
      spq_pkg::ST_DISPATCH: begin
        if (stat.is_deq) begin
          if (stat.empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = spq_pkg::STAT_EMPTY;
            state_nxt      = spq_pkg::ST_HEAD_RD;
          end else begin
            state_nxt = spq_pkg::ST_DEQ_RD;
          end
        end else if (stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = spq_pkg::STAT_FULL;
          state_nxt      = spq_pkg::ST_HEAD_RD;
        end else begin
          cmd.pos_load = 1'b1;
          state_nxt    = spq_pkg::ST_SCAN_RD;
        end
      end
      spq_pkg::ST_SCAN_RD: begin
        if (stat.pos_zero) begin
          cmd.ins_wr = 1'b1;
          state_nxt  = spq_pkg::ST_HEAD_RD;
        end else begin
          cmd.rd_sel = spq_pkg::RD_SCAN;
          state_nxt  = spq_pkg::ST_SCAN_CMP;
        end
      end
      spq_pkg::ST_SCAN_CMP: begin
        if (stat.greater) begin
          cmd.shift_wr = 1'b1;
          cmd.pos_dec  = 1'b1;
          state_nxt    = spq_pkg::ST_SCAN_RD;
        end else begin
          cmd.ins_wr = 1'b1;
          state_nxt  = spq_pkg::ST_HEAD_RD;
        end
      end
      spq_pkg::ST_DEQ_RD: begin
        state_nxt = spq_pkg::ST_DEQ_CAP;
      end
      spq_pkg::ST_DEQ_CAP: begin
        cmd.deq_commit = 1'b1;
        state_nxt      = spq_pkg::ST_HEAD_RD;
      end
      spq_pkg::ST_HEAD_RD: begin
        state_nxt = spq_pkg::ST_FINISH;
      end
      spq_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/spq_dpath.sv]
// Datapath for the sorted priority queue: ring-addressed pair store, scan
// position, count, captured request and the result register.
// Depends on spq_pkg and spq_ram.
`timescale 1ns / 1ps

module spq_dpath #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::dp_cmd_t                    cmd,
  output spq_pkg::dp_stat_t                   stat,
  input  logic [spq_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  input  logic [spq_pkg::IN_TUSER_BITS-1:0]   in_tuser,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [spq_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic [spq_pkg::OUT_TUSER_BITS-1:0]  out_tuser
);

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = PRIORITY_BITS + VALUE_BITS;
  localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Map a position counted from the head onto a physical slot.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_SUM) begin
      sum = sum - CAP_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic                     op_r;
  logic [PRIORITY_BITS-1:0] req_prio_r;
  logic [VALUE_BITS-1:0]    req_val_r;
  spq_pkg::status_t         status_r;
  logic [PRIORITY_BITS-1:0] rem_prio_r;
  logic [VALUE_BITS-1:0]    rem_val_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [spq_pkg::OUT_TDATA_BITS-1:0] out_tdata_r, out_tdata_nxt;
  logic [spq_pkg::OUT_TUSER_BITS-1:0] out_tuser_r;

  logic [PRIORITY_BITS+spq_pkg::IN_PRIO_BITS-1:0]   in_prio_ext;
  logic [VALUE_BITS+spq_pkg::IN_VALUE_BITS-1:0]     in_val_ext;
  logic [ENTRY_W-1:0]                               rd_data;
  logic [ENTRY_W-1:0]                               wr_data;
  logic [IDX_W-1:0]                                 rd_addr;
  logic [IDX_W-1:0]                                 wr_addr;
  logic                                             wr_en;
  logic [PRIORITY_BITS-1:0]                         rd_prio;
  logic [VALUE_BITS-1:0]                            rd_val;
  logic [VALUE_BITS-1:0]                            head_val;
  logic [PRIORITY_BITS+spq_pkg::OUT_PRIO_BITS-1:0]  rem_prio_ext;
  logic [VALUE_BITS+spq_pkg::OUT_VALUE_BITS-1:0]    rem_val_ext;
  logic [VALUE_BITS+spq_pkg::OUT_VALUE_BITS-1:0]    head_val_ext;
  logic [CNT_W+spq_pkg::OUT_COUNT_BITS-1:0]         count_ext;
  logic                                             out_free;

  // Take the low bits of the request fields as raw patterns.
  assign in_prio_ext = {{PRIORITY_BITS{1'b0}}, in_tdata[15:0]};
  assign in_val_ext  = {{VALUE_BITS{1'b0}}, in_tdata[47:16]};

  assign rd_prio = rd_data[ENTRY_W-1:VALUE_BITS];
  assign rd_val  = rd_data[VALUE_BITS-1:0];

  assign rd_addr = (cmd.rd_sel == spq_pkg::RD_SCAN) ? phys_idx(head_r, pos_r - 1'b1)
                                                    : head_r;
  assign wr_addr = phys_idx(head_r, pos_r);
  assign wr_en   = cmd.shift_wr | cmd.ins_wr;
  assign wr_data = cmd.shift_wr ? rd_data : {req_prio_r, req_val_r};

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    stat.is_deq   = (op_r == spq_pkg::OP_DEQ);
    stat.full     = (count_r == CAP_CNT);
    stat.empty    = (count_r == '0);
    stat.pos_zero = (pos_r == '0);
    stat.greater  = ($signed(rd_prio) > $signed(req_prio_r));
    stat.out_free = out_free;
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    if (cmd.pos_load) begin
      pos_nxt = count_r[IDX_W-1:0];
    end else if (cmd.pos_dec) begin
      pos_nxt = pos_r - 1'b1;
    end
    if (cmd.ins_wr) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.deq_commit) begin
      count_nxt = count_r - 1'b1;
      head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
  end

  // Result word assembly; the read port sits on the head slot in the finish state.
  assign head_val     = (count_r == '0) ? '0 : rd_val;
  assign rem_prio_ext = {{spq_pkg::OUT_PRIO_BITS{rem_prio_r[PRIORITY_BITS-1]}}, rem_prio_r};
  assign rem_val_ext  = {{spq_pkg::OUT_VALUE_BITS{1'b0}}, rem_val_r};
  assign head_val_ext = {{spq_pkg::OUT_VALUE_BITS{1'b0}}, head_val};
  assign count_ext    = {{spq_pkg::OUT_COUNT_BITS{1'b0}}, count_r};
  assign out_tdata_nxt = {1'b0,
                          count_ext[spq_pkg::OUT_COUNT_BITS-1:0],
                          stat.full,
                          stat.empty,
                          head_val_ext[spq_pkg::OUT_VALUE_BITS-1:0],
                          rem_val_ext[spq_pkg::OUT_VALUE_BITS-1:0],
                          rem_prio_ext[spq_pkg::OUT_PRIO_BITS-1:0]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r       <= in_tuser[0];
      req_prio_r <= in_prio_ext[PRIORITY_BITS-1:0];
      req_val_r  <= in_val_ext[VALUE_BITS-1:0];
      status_r   <= spq_pkg::STAT_DONE;
      rem_prio_r <= '0;
      rem_val_r  <= '0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.deq_commit) begin
        rem_prio_r <= rd_prio;
        rem_val_r  <= rd_val;
      end
    end
    if (cmd.out_load) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("pair count above capacity");

  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> count_r != CAP_CNT)
    else $error("insert while full");

  a_deq_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq_commit |-> count_r != '0)
    else $error("remove while empty");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result word overwritten before it was taken");

endmodule

[hw/rtl/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue.
// Depends on spq_pkg, spq_ctrl, spq_dpath (and spq_ram beneath it).
`timescale 1ns / 1ps

// Bounded min-first priority queue of (priority, value) pairs. Each input word
// is an enqueue (in_tuser = 0) or a dequeue (in_tuser = 1) and yields exactly
// one result word. Pairs are kept sorted in a ring-addressed RAM; equal
// priorities leave in arrival order. An enqueue on a full queue returns
// status 1 and a dequeue on an empty queue returns status 2, both leaving the
// queue untouched. Each result also carries the head value, empty and full
// flags and the pair count as they stand after the operation. One word is
// worked on at a time, and a new word is taken while an earlier result still
// waits in the output register. After dispatch, a refused operation goes
// straight to the head read and the finish step; a dequeue first reads and
// removes the head pair; an enqueue first runs the insertion scan, which
// reads and compares stored pairs from the tail toward the head, moves each
// one with a larger priority one slot toward the tail, and then writes the
// new pair. The controller is back in idle once the result is loaded and
// only then takes the next word; while the output register still holds an
// untaken result, the finish step waits. The scan works on one stored pair
// at a time through the single RAM read port; a dequeue only advances the
// head pointer. The store needs no clearing after reset.
module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] priority_req, [47:16] value
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [15:0] out_priority, [47:16] out_value,
                                  // [79:48] head_value, [80] empty_res,
                                  // [81] full_res, [86:82] count, [87] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  spq_pkg::dp_cmd_t  cmd;
  spq_pkg::dp_stat_t stat;

  // Sequence each word: dispatch, scan or remove, refresh the head, publish.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the pair store, pointers and the result register.
  spq_dpath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[tb/tb_sorted_priority_queue_top.sv]
// Self-checking testbench for sorted_priority_queue_top: directed table, then random phases.
// Predicts every result word in-line and checks it field by field; depends on spq_pkg.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_WORDS = 1700;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned REPORT_LIMIT = 10;

  // One result word, unpacked into its fields.
  typedef struct packed {
    spq_pkg::status_t   status;
    logic signed [15:0] prio;
    logic [31:0]        val;
    logic [31:0]        head;
    logic               empty;
    logic               full;
    logic [4:0]         count;
  } queue_result_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic               op;
    logic signed [15:0] prio;
    logic [31:0]        val;
    logic               typed;
    queue_result_t      want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [15:0] priority_req, [47:16] value
  logic [0:0]  in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // [15:0] out_priority, [47:16] out_value, [79:48] head_value,
                           // [80] empty_res, [81] full_res, [86:82] count, [87] zero
  logic [1:0]  out_tuser;  // [1:0] status

  sorted_priority_queue_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Shadow of the sorted store: slot 0 is the head.
  logic signed [15:0] shadow_prio [DEPTH];
  logic [31:0]        shadow_val  [DEPTH];
  int unsigned        shadow_count;

  queue_result_t pending_results [$];
  int unsigned   mismatch_count;
  bit            steady_sender;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Apply one operation to the shadow store and return the word it must produce.
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic signed [15:0] prio,
                                                   input logic [31:0] val);
    queue_result_t res;
    int unsigned   pos;
    res = '0;
    res.status = spq_pkg::STAT_DONE;
    if (op == spq_pkg::OP_ENQ) begin
      if (shadow_count >= DEPTH) begin
        res.status = spq_pkg::STAT_FULL;
      end else begin
        // Slide strictly larger priorities toward the tail; ties stay in front.
        pos = shadow_count;
        while (pos > 0 && shadow_prio[pos-1] > prio) begin
          shadow_prio[pos] = shadow_prio[pos-1];
          shadow_val[pos]  = shadow_val[pos-1];
          pos--;
        end
        shadow_prio[pos] = prio;
        shadow_val[pos]  = val;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = spq_pkg::STAT_EMPTY;
      end else begin
        res.prio = shadow_prio[0];
        res.val  = shadow_val[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_val[i-1]  = shadow_val[i];
        end
        shadow_count--;
      end
    end
    res.head  = (shadow_count > 0) ? shadow_val[0] : 32'h0;
    res.empty = (shadow_count == 0);
    res.full  = (shadow_count == DEPTH);
    res.count = shadow_count[4:0];
    return res;
  endfunction

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word, hold it until taken, then predict and idle for a while.
  task automatic send_word(input logic op, input logic signed [15:0] prio,
                           input logic [31:0] val, input logic typed,
                           input queue_result_t want);
    queue_result_t guess;
    int unsigned   gap;
    in_tvalid   <= 1'b1;
    in_tuser[0] <= op;
    in_tdata    <= {val, prio};
    do @(posedge clk); while (!in_tready);
    guess = apply_queue_op(op, prio, val);
    pending_results.push_back(typed ? want : guess);
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      // Drop valid and scramble the data bus while idle.
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom(), 16'($urandom())};
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: bursts of ready, some long, separated by random stalls.
  initial begin
    int unsigned run;
    int unsigned gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run = ($urandom_range(99) < 25) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = spq_pkg::status_t'(out_tuser);
      got.prio   = out_tdata[15:0];
      got.val    = out_tdata[47:16];
      got.head   = out_tdata[79:48];
      got.empty  = out_tdata[80];
      got.full   = out_tdata[81];
      got.count  = out_tdata[86:82];
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result word at %0t: status %0d count %0d",
                   $time, out_tuser, got.count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status || got.prio !== want.prio || got.val !== want.val ||
            got.head !== want.head || got.empty !== want.empty ||
            got.full !== want.full || got.count !== want.count) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("mismatch at %0t: want status %0d prio %0d val %h head %h e%b f%b n%0d",
                     $time, want.status, want.prio, want.val, want.head, want.empty,
                     want.full, want.count);
            $display("                 got  status %0d prio %0d val %h head %h e%b f%b n%0d",
                     out_tuser, got.prio, got.val, got.head, got.empty, got.full,
                     got.count);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t           dir_table [23];
    int unsigned        sent;
    int unsigned        phase_len;
    int unsigned        enq_pct;
    int unsigned        pick;
    bit                 tie_phase;
    logic               op;
    logic signed [15:0] prio;
    logic [31:0]        val;

    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= '0;
    shadow_count   = 0;
    mismatch_count = 0;
    steady_sender  = 1'b0;

    // Empty dequeue, extreme pairs, ties at both ends, fill to the brim, full refusal.
    dir_table[0]  = '{spq_pkg::OP_DEQ, 16'sh0000, 32'h0000_0000, 1'b1,
      '{spq_pkg::STAT_EMPTY, 16'sh0000, 32'h0, 32'h0, 1'b1, 1'b0, 5'd0}};
    dir_table[1]  = '{spq_pkg::OP_ENQ, 16'sh7fff, 32'h7fff_ffff, 1'b1,
      '{spq_pkg::STAT_DONE, 16'sh0000, 32'h0, 32'h7fff_ffff, 1'b0, 1'b0, 5'd1}};
    dir_table[2]  = '{spq_pkg::OP_ENQ, 16'sh8000, 32'h8000_0000, 1'b1,
      '{spq_pkg::STAT_DONE, 16'sh0000, 32'h0, 32'h8000_0000, 1'b0, 1'b0, 5'd2}};
    dir_table[3]  = '{spq_pkg::OP_ENQ, 16'sh0000, 32'hffff_ffff, 1'b0, '0};
    dir_table[4]  = '{spq_pkg::OP_ENQ, 16'sh0000, 32'h0000_0001, 1'b0, '0};
    dir_table[5]  = '{spq_pkg::OP_ENQ, 16'sh8000, 32'h5555_aaaa, 1'b0, '0};
    dir_table[6]  = '{spq_pkg::OP_DEQ, 16'sh1234, 32'hffff_ffff, 1'b0, '0};
    dir_table[7]  = '{spq_pkg::OP_DEQ, 16'shffff, 32'h0000_0000, 1'b0, '0};
    dir_table[8]  = '{spq_pkg::OP_ENQ, 16'sd1000, 32'h0000_0000, 1'b0, '0};
    dir_table[9]  = '{spq_pkg::OP_ENQ, 16'sd900, 32'h1234_5678, 1'b0, '0};
    dir_table[10] = '{spq_pkg::OP_ENQ, 16'sd800, 32'haaaa_5555, 1'b0, '0};
    dir_table[11] = '{spq_pkg::OP_ENQ, 16'sh7fff, 32'h0bad_cafe, 1'b0, '0};
    dir_table[12] = '{spq_pkg::OP_ENQ, 16'sd1, 32'h0000_0011, 1'b0, '0};
    dir_table[13] = '{spq_pkg::OP_ENQ, 16'sd700, 32'h0000_0700, 1'b0, '0};
    dir_table[14] = '{spq_pkg::OP_ENQ, 16'sd600, 32'h0000_0600, 1'b0, '0};
    dir_table[15] = '{spq_pkg::OP_ENQ, 16'sd500, 32'h0000_0500, 1'b0, '0};
    dir_table[16] = '{spq_pkg::OP_ENQ, 16'sd400, 32'h0000_0400, 1'b0, '0};
    dir_table[17] = '{spq_pkg::OP_ENQ, 16'sd300, 32'h0000_0300, 1'b0, '0};
    dir_table[18] = '{spq_pkg::OP_ENQ, 16'sd200, 32'h0000_0200, 1'b0, '0};
    dir_table[19] = '{spq_pkg::OP_ENQ, 16'sd100, 32'h0000_0100, 1'b0, '0};
    dir_table[20] = '{spq_pkg::OP_ENQ, 16'sd1, 32'h0000_0022, 1'b0, '0};
    dir_table[21] = '{spq_pkg::OP_ENQ, 16'sd5, 32'hdead_0001, 1'b1,
      '{spq_pkg::STAT_FULL, 16'sh0000, 32'h0, 32'hffff_ffff, 1'b0, 1'b1, 5'd16}};
    dir_table[22] = '{spq_pkg::OP_DEQ, 16'sh0000, 32'h0000_0000, 1'b0, '0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i])
      send_word(dir_table[i].op, dir_table[i].prio, dir_table[i].val,
                dir_table[i].typed, dir_table[i].want);

    // Random phases: fill-heavy, drain-heavy, balanced, and balanced with dense ties.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick          = $urandom_range(3);
      enq_pct       = (pick == 0) ? 85 : (pick == 1) ? 20 : 50;
      tie_phase     = (pick == 3);
      steady_sender = ($urandom_range(3) == 0);
      phase_len     = $urandom_range(10, 80);
      for (int k = 0; k < phase_len; k++) begin
        op   = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
        pick = $urandom_range(9);
        if (tie_phase || pick < 3)
          prio = 16'($urandom_range(8)) - 16'd4;
        else if (pick == 3)
          prio = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else
          prio = 16'($urandom());
        val = $urandom();
        // Now and then force an all-zero, all-one or sign-boundary value.
        if ($urandom_range(15) == 0)
          val = {val[0], {31{val[1]}}};
        send_word(op, prio, val, 1'b0, '0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
